@@ src/rqsm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rqsm_pkg
// Shared widths, limits and command codes for the ring queue slot manager.
// ----------------------------------------------------------------------------
package rqsm_pkg;

  localparam int unsigned MAX_SLOTS      = 1024;
  localparam int unsigned MAX_ELEM_BYTES = 4096;

  localparam int unsigned PTR_W  = 10;
  localparam int unsigned CNT_W  = 11;
  localparam int unsigned SIZE_W = 13;
  localparam int unsigned OFF_W  = 22;
  localparam int unsigned CMD_W  = 3;
  localparam int unsigned CFG_W  = 13;

  typedef logic [PTR_W-1:0]  ptr_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [SIZE_W-1:0] size_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_RESET     = 3'd0,
    CMD_PEEK      = 3'd1,
    CMD_POP       = 3'd2,
    CMD_ALLOC     = 3'd3,
    CMD_ALLOC_RUN = 3'd4,
    CMD_FREE      = 3'd5,
    CMD_STATUS    = 3'd6
  } cmd_e;

  typedef enum logic {
    CFG_CAPACITY  = 1'b0,
    CFG_ELEM_SIZE = 1'b1
  } cfg_e;

endpackage

@@ src/ring_queue_slot_manager.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ring_queue_slot_manager
// Head, tail and fill count of a circular slot queue, one request per cycle unless stalled.
// ----------------------------------------------------------------------------
// path: a request is registered in the request register on acceptance, and its
//   result is registered in the result register when the request completes
// throughput: one request per cycle while the output is not stalled; a pointer
//   wrap whose operand is at least twice the capacity (only after capacity is
//   lowered) holds the request in the bit-serial remainder unit
// reset: asynchronous, clears pointers and fill count, capacity 1024, size 1
module ring_queue_slot_manager (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic                            cfg_idx_i,
  input  logic [rqsm_pkg::CFG_W-1:0]      cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [rqsm_pkg::CMD_W-1:0]      command_i,
  input  logic [rqsm_pkg::CNT_W-1:0]      count_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            error_o,
  output logic [rqsm_pkg::PTR_W-1:0]      slot_index_o,
  output logic [rqsm_pkg::OFF_W-1:0]      byte_offset_o,
  output logic [rqsm_pkg::CNT_W-1:0]      fill_count_o,
  output logic                            has_space_o
);

  localparam int unsigned PTR_W  = rqsm_pkg::PTR_W;
  localparam int unsigned CNT_W  = rqsm_pkg::CNT_W;
  localparam int unsigned SIZE_W = rqsm_pkg::SIZE_W;
  localparam int unsigned OFF_W  = rqsm_pkg::OFF_W;
  localparam int unsigned PROD_W = PTR_W + SIZE_W;
  localparam logic [3:0]  DivLast = 4'(CNT_W - 1);

  // configuration
  rqsm_pkg::cnt_t  capacity_q;
  rqsm_pkg::size_t elem_size_q;

  // queue state
  rqsm_pkg::ptr_t head_q, head_d;
  rqsm_pkg::ptr_t tail_q, tail_d;
  rqsm_pkg::cnt_t occ_q, occ_d;

  // request register
  logic            req_valid_q;
  rqsm_pkg::cmd_e  cmd_q;
  rqsm_pkg::cnt_t  count_q;

  // result register
  logic            out_valid_q;
  logic            out_error_q;
  rqsm_pkg::ptr_t  out_index_q;
  logic [OFF_W-1:0] out_offset_q;
  rqsm_pkg::cnt_t  out_fill_q;
  logic            out_space_q;

  // bit-serial remainder unit
  logic            div_busy_q;
  logic            div_done_q;
  logic [3:0]      div_cnt_q;
  rqsm_pkg::cnt_t  div_x_q;
  rqsm_pkg::ptr_t  div_rem_q;
  rqsm_pkg::cnt_t  div_t;
  rqsm_pkg::ptr_t  div_rem_d;

  rqsm_pkg::cnt_t  cap;
  rqsm_pkg::size_t size_eff;
  logic [CNT_W:0]  cap2;
  logic [CNT_W:0]  sum_tn;
  logic [CNT_W:0]  sum_on;
  rqsm_pkg::cnt_t  mod_x;
  logic            x_ge_cap;
  logic            x_ge_2cap;
  rqsm_pkg::ptr_t  mod_val;
  logic            err;
  logic            mod_use;
  rqsm_pkg::ptr_t  idx;
  logic [PROD_W-1:0] prod;
  logic            wait_div;
  logic            div_start;
  logic            s1_fire;

  // effective configuration
  always_comb begin
    if (capacity_q == '0) begin
      cap = CNT_W'(1);
    end else if (capacity_q > CNT_W'(rqsm_pkg::MAX_SLOTS)) begin
      cap = CNT_W'(rqsm_pkg::MAX_SLOTS);
    end else begin
      cap = capacity_q;
    end
    if (elem_size_q > SIZE_W'(rqsm_pkg::MAX_ELEM_BYTES)) begin
      size_eff = SIZE_W'(rqsm_pkg::MAX_ELEM_BYTES);
    end else begin
      size_eff = elem_size_q;
    end
  end

  assign cap2   = {cap, 1'b0};
  assign sum_tn = {2'b00, tail_q} + {1'b0, count_q};
  assign sum_on = {1'b0, occ_q} + {1'b0, count_q};

  // wrap operand
  always_comb begin
    case (cmd_q)
      rqsm_pkg::CMD_POP:       mod_x = {1'b0, head_q} + CNT_W'(1);
      rqsm_pkg::CMD_ALLOC:     mod_x = {1'b0, tail_q} + CNT_W'(1);
      rqsm_pkg::CMD_ALLOC_RUN: mod_x = sum_tn[CNT_W-1:0];
      rqsm_pkg::CMD_FREE:      mod_x = count_q - {1'b0, tail_q};
      default:                 mod_x = '0;
    endcase
  end

  assign x_ge_cap  = mod_x >= cap;
  assign x_ge_2cap = {1'b0, mod_x} >= cap2;

  always_comb begin
    if (x_ge_2cap) begin
      mod_val = div_rem_q;
    end else if (x_ge_cap) begin
      mod_val = PTR_W'(mod_x - cap);
    end else begin
      mod_val = mod_x[PTR_W-1:0];
    end
  end

  // command decode and next state
  always_comb begin
    err     = 1'b0;
    mod_use = 1'b0;
    idx     = '0;
    head_d  = head_q;
    tail_d  = tail_q;
    occ_d   = occ_q;
    unique case (cmd_q)
      rqsm_pkg::CMD_RESET: begin
        head_d = '0;
        tail_d = '0;
        occ_d  = '0;
      end
      rqsm_pkg::CMD_PEEK: begin
        if (occ_q == '0) begin
          err = 1'b1;
        end else begin
          idx = head_q;
        end
      end
      rqsm_pkg::CMD_POP: begin
        if (occ_q == '0) begin
          err = 1'b1;
        end else begin
          idx     = head_q;
          mod_use = 1'b1;
          head_d  = mod_val;
          occ_d   = occ_q - CNT_W'(1);
        end
      end
      rqsm_pkg::CMD_ALLOC: begin
        if (occ_q >= cap) begin
          err = 1'b1;
        end else begin
          idx     = tail_q;
          mod_use = 1'b1;
          tail_d  = mod_val;
          occ_d   = occ_q + CNT_W'(1);
        end
      end
      rqsm_pkg::CMD_ALLOC_RUN: begin
        if (count_q == '0 || sum_on > {1'b0, cap} || sum_tn > {1'b0, cap}) begin
          err = 1'b1;
        end else begin
          idx     = tail_q;
          mod_use = 1'b1;
          tail_d  = mod_val;
          occ_d   = sum_on[CNT_W-1:0];
        end
      end
      rqsm_pkg::CMD_FREE: begin
        if (count_q > occ_q) begin
          err = 1'b1;
        end else begin
          occ_d = occ_q - count_q;
          if (count_q <= {1'b0, tail_q}) begin
            tail_d = tail_q - count_q[PTR_W-1:0];
          end else begin
            mod_use = 1'b1;
            if (mod_val == '0) begin
              tail_d = '0;
            end else begin
              tail_d = PTR_W'(cap - {1'b0, mod_val});
            end
          end
        end
      end
      rqsm_pkg::CMD_STATUS: begin
      end
      default: begin
        err = 1'b1;
      end
    endcase
  end

  assign prod = PROD_W'(idx) * PROD_W'(size_eff);

  assign wait_div  = mod_use && x_ge_2cap && !div_done_q;
  assign div_start = req_valid_q && wait_div && !div_busy_q;
  assign s1_fire   = req_valid_q && !wait_div && (!out_valid_q || out_ready_i);
  assign in_ready_o = !req_valid_q || s1_fire;

  assign div_t     = {div_rem_q, div_x_q[CNT_W-1]};
  assign div_rem_d = (div_t >= cap) ? PTR_W'(div_t - cap) : div_t[PTR_W-1:0];

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q  <= CNT_W'(rqsm_pkg::MAX_SLOTS);
      elem_size_q <= SIZE_W'(1);
    end else if (cfg_we_i) begin
      unique case (rqsm_pkg::cfg_e'(cfg_idx_i))
        rqsm_pkg::CFG_CAPACITY:  capacity_q  <= cfg_data_i[CNT_W-1:0];
        rqsm_pkg::CFG_ELEM_SIZE: elem_size_q <= cfg_data_i[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // request register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      req_valid_q <= 1'b1;
    end else if (s1_fire) begin
      req_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cmd_q   <= rqsm_pkg::cmd_e'(command_i);
      count_q <= count_i;
    end
  end

  // queue state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      occ_q  <= '0;
    end else if (s1_fire) begin
      head_q <= head_d;
      tail_q <= tail_d;
      occ_q  <= occ_d;
    end
  end

  // remainder unit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_busy_q <= 1'b0;
      div_done_q <= 1'b0;
      div_cnt_q  <= '0;
    end else if (div_start) begin
      div_busy_q <= 1'b1;
      div_cnt_q  <= '0;
    end else if (div_busy_q) begin
      div_cnt_q <= div_cnt_q + 4'd1;
      if (div_cnt_q == DivLast) begin
        div_busy_q <= 1'b0;
        div_done_q <= 1'b1;
      end
    end else if (s1_fire) begin
      div_done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_start) begin
      div_x_q   <= mod_x;
      div_rem_q <= '0;
    end else if (div_busy_q) begin
      div_x_q   <= {div_x_q[CNT_W-2:0], 1'b0};
      div_rem_q <= div_rem_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      out_error_q  <= err;
      out_index_q  <= idx;
      out_offset_q <= prod[OFF_W-1:0];
      out_fill_q   <= occ_d;
      out_space_q  <= occ_d < cap;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign error_o       = out_error_q;
  assign slot_index_o  = out_index_q;
  assign byte_offset_o = out_offset_q;
  assign fill_count_o  = out_fill_q;
  assign has_space_o   = out_space_q;

  // checks
  a_div_needs_req : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_busy_q |-> req_valid_q)
    else $error("remainder unit busy with no request held");

  a_div_exclusive : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(div_busy_q && div_done_q))
    else $error("remainder unit busy and done at once");

  a_err_keeps_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && err |=> $stable(head_q) && $stable(tail_q) && $stable(occ_q))
    else $error("refused request changed queue state");

  a_fill_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= CNT_W'(rqsm_pkg::MAX_SLOTS))
    else $error("fill count beyond slot limit");

  a_fire_gives_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire |=> out_valid_q)
    else $error("completed request produced no result");

endmodule

@@ bench/tb_ring_queue_slot_manager.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ring_queue_slot_manager
// Self-checking bench for the ring queue slot manager. Every accepted request
// is run through a behavioural copy of the pointer logic, and each returned
// result is compared field by field against the oldest pending prediction.
// Directed sequences cover empty, full, refused and wrapped cases and the
// register extremes. Random phases then follow, each under its own setting,
// with bursty gaps on both handshakes, one long output stall and a clean tail.
// ----------------------------------------------------------------------------
module tb_ring_queue_slot_manager;

  localparam int unsigned PTR_W          = rqsm_pkg::PTR_W;
  localparam int unsigned CNT_W          = rqsm_pkg::CNT_W;
  localparam int unsigned OFF_W          = rqsm_pkg::OFF_W;
  localparam int unsigned CMD_W          = rqsm_pkg::CMD_W;
  localparam int unsigned CFG_W          = rqsm_pkg::CFG_W;
  localparam int unsigned MAX_SLOTS      = rqsm_pkg::MAX_SLOTS;
  localparam int unsigned MAX_ELEM_BYTES = rqsm_pkg::MAX_ELEM_BYTES;

  localparam logic [CMD_W-1:0] CMD_UNKNOWN = 3'd7;
  localparam int unsigned MAX_REPORTS = 10;

  typedef struct packed {
    logic             err;
    rqsm_pkg::ptr_t   slot;
    logic [OFF_W-1:0] offset;
    rqsm_pkg::cnt_t   fill;
    logic             space;
  } slot_result_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i = 1'b0;
  logic             cfg_idx_i = 1'b0;
  logic [CFG_W-1:0] cfg_data_i = '0;
  logic             in_valid_i = 1'b0;
  logic             in_ready_o;
  logic [CMD_W-1:0] command_i = '0;
  rqsm_pkg::cnt_t   count_i = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  logic             error_o;
  rqsm_pkg::ptr_t   slot_index_o;
  logic [OFF_W-1:0] byte_offset_o;
  rqsm_pkg::cnt_t   fill_count_o;
  logic             has_space_o;

  // predictor state
  rqsm_pkg::cnt_t   cap_reg = 11'd1024;
  rqsm_pkg::size_t  size_reg = 13'd1;
  int unsigned      q_head = 0;
  int unsigned      q_tail = 0;
  int unsigned      q_fill = 0;
  slot_result_t     slot_expect_q[$];
  int unsigned      mismatch_count = 0;

  bit               tx_idle_on = 1'b1;
  bit               rx_stall_on = 1'b1;
  int unsigned      rx_hold_len = 0;

  ring_queue_slot_manager dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .command_i     (command_i),
    .count_i       (count_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .error_o       (error_o),
    .slot_index_o  (slot_index_o),
    .byte_offset_o (byte_offset_o),
    .fill_count_o  (fill_count_o),
    .has_space_o   (has_space_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned ring_cap();
    if (cap_reg == 0) return 1;
    if (cap_reg > MAX_SLOTS) return MAX_SLOTS;
    return cap_reg;
  endfunction

  function automatic int unsigned wrap_fwd(int unsigned p, int unsigned n, int unsigned cap);
    int unsigned q;
    q = p + n;
    return (q >= cap) ? q % cap : q;
  endfunction

  function automatic slot_result_t apply_request(logic [CMD_W-1:0] cmd, rqsm_pkg::cnt_t cnt);
    int unsigned  cap, esize, slot, n, r;
    slot_result_t res;
    cap   = ring_cap();
    esize = (size_reg > MAX_ELEM_BYTES) ? MAX_ELEM_BYTES : size_reg;
    n     = cnt;
    slot  = 0;
    res.err = 1'b0;
    case (cmd)
      rqsm_pkg::CMD_RESET: begin
        q_head = 0;
        q_tail = 0;
        q_fill = 0;
      end
      rqsm_pkg::CMD_PEEK: begin
        if (q_fill == 0) res.err = 1'b1;
        else slot = q_head;
      end
      rqsm_pkg::CMD_POP: begin
        if (q_fill == 0) begin
          res.err = 1'b1;
        end else begin
          slot   = q_head;
          q_head = wrap_fwd(q_head, 1, cap);
          q_fill = q_fill - 1;
        end
      end
      rqsm_pkg::CMD_ALLOC: begin
        if (q_fill >= cap) begin
          res.err = 1'b1;
        end else begin
          slot   = q_tail;
          q_tail = wrap_fwd(q_tail, 1, cap);
          q_fill = q_fill + 1;
        end
      end
      rqsm_pkg::CMD_ALLOC_RUN: begin
        if (n == 0 || q_fill + n > cap || q_tail + n > cap) begin
          res.err = 1'b1;
        end else begin
          slot   = q_tail;
          q_tail = wrap_fwd(q_tail, n, cap);
          q_fill = q_fill + n;
        end
      end
      rqsm_pkg::CMD_FREE: begin
        if (n > q_fill) begin
          res.err = 1'b1;
        end else begin
          // moving back wraps modulo the ring size
          if (n <= q_tail) begin
            q_tail = q_tail - n;
          end else begin
            r      = (n - q_tail) % cap;
            q_tail = (r == 0) ? 0 : cap - r;
          end
          q_fill = q_fill - n;
        end
      end
      rqsm_pkg::CMD_STATUS: ;
      default: res.err = 1'b1;
    endcase
    slot       = slot % 1024;
    r          = slot * esize;
    res.slot   = slot[PTR_W-1:0];
    res.offset = r[OFF_W-1:0];
    res.fill   = q_fill[CNT_W-1:0];
    res.space  = (q_fill < cap);
    return res;
  endfunction

  function automatic void note_mismatch(string what, int unsigned want, int unsigned got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
  endfunction

  // predict on each accepted request, check each accepted result
  always @(posedge clk_i) begin
    slot_result_t want;
    if (rst_ni) begin
      if (cfg_we_i) begin
        if (cfg_idx_i == rqsm_pkg::CFG_CAPACITY) cap_reg = cfg_data_i[CNT_W-1:0];
        else size_reg = cfg_data_i;
      end
      if (in_valid_i && in_ready_o)
        slot_expect_q.push_back(apply_request(command_i, count_i));
      if (out_valid_o && out_ready_i) begin
        if (slot_expect_q.size() == 0) begin
          note_mismatch("unrequested result, fill_count", 0, fill_count_o);
        end else begin
          want = slot_expect_q.pop_front();
          if (error_o !== want.err) note_mismatch("error", want.err, error_o);
          if (slot_index_o !== want.slot) note_mismatch("slot_index", want.slot, slot_index_o);
          if (byte_offset_o !== want.offset)
            note_mismatch("byte_offset", want.offset, byte_offset_o);
          if (fill_count_o !== want.fill) note_mismatch("fill_count", want.fill, fill_count_o);
          if (has_space_o !== want.space) note_mismatch("has_space", want.space, has_space_o);
        end
      end
    end
  end

  // result side: random stall bursts, or one long hold when asked
  initial begin
    int unsigned n;
    forever begin
      @(posedge clk_i);
      if (rx_hold_len != 0) begin
        n = rx_hold_len;
        rx_hold_len = 0;
        out_ready_i <= 1'b0;
        repeat (n - 1) @(posedge clk_i);
      end else if (rx_stall_on && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(0, 13)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic send_req(logic [CMD_W-1:0] cmd, rqsm_pkg::cnt_t cnt);
    if (tx_idle_on && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i  <= cmd;
    count_i    <= cnt;
    do begin
      @(posedge clk_i);
    end while (!in_ready_o);
  endtask

  task automatic wait_drained(int unsigned tail_cycles = 4);
    in_valid_i <= 1'b0;
    do begin
      @(posedge clk_i);
    end while (slot_expect_q.size() != 0);
    repeat (tail_cycles) @(posedge clk_i);
  endtask

  task automatic write_reg(rqsm_pkg::cfg_e idx, logic [CFG_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_random_req();
    logic [CMD_W-1:0] cmd;
    int unsigned      n, sel;
    sel = $urandom_range(0, 99);
    n   = $urandom_range(0, 2047);
    if (sel < 24) begin
      cmd = rqsm_pkg::CMD_ALLOC;
    end else if (sel < 44) begin
      cmd = rqsm_pkg::CMD_POP;
    end else if (sel < 58) begin
      cmd = rqsm_pkg::CMD_ALLOC_RUN;
      n   = $urandom_range(1, ring_cap() + 1);
    end else if (sel < 70) begin
      cmd = rqsm_pkg::CMD_FREE;
      n   = $urandom_range(0, q_fill + 1);
    end else if (sel < 80) begin
      cmd = rqsm_pkg::CMD_PEEK;
    end else if (sel < 88) begin
      cmd = rqsm_pkg::CMD_STATUS;
    end else if (sel < 91) begin
      cmd = rqsm_pkg::CMD_RESET;
    end else if (sel < 94) begin
      cmd = CMD_UNKNOWN;
    end else begin
      cmd = CMD_W'($urandom_range(0, 7));
    end
    send_req(cmd, n[CNT_W-1:0]);
  endtask

  task automatic test_empty_and_full();
    send_req(rqsm_pkg::CMD_STATUS, 11'd0);
    send_req(rqsm_pkg::CMD_PEEK, 11'd0);
    send_req(rqsm_pkg::CMD_POP, 11'd2047);
    send_req(rqsm_pkg::CMD_FREE, 11'd1);
    send_req(rqsm_pkg::CMD_FREE, 11'd0);
    send_req(rqsm_pkg::CMD_ALLOC_RUN, 11'd0);
    send_req(rqsm_pkg::CMD_ALLOC, 11'd0);
    send_req(rqsm_pkg::CMD_ALLOC_RUN, 11'd1024);
    send_req(rqsm_pkg::CMD_ALLOC_RUN, 11'd1023);
    send_req(rqsm_pkg::CMD_ALLOC, 11'd0);
    send_req(rqsm_pkg::CMD_ALLOC_RUN, 11'd1);
    send_req(rqsm_pkg::CMD_PEEK, 11'd0);
    send_req(rqsm_pkg::CMD_POP, 11'd0);
    send_req(rqsm_pkg::CMD_FREE, 11'd2047);
    send_req(rqsm_pkg::CMD_FREE, 11'd1023);
    send_req(CMD_UNKNOWN, 11'd2047);
    send_req(rqsm_pkg::CMD_RESET, 11'd2047);
    send_req(rqsm_pkg::CMD_PEEK, 11'd0);
  endtask

  task automatic test_register_extremes();
    wait_drained();
    // capacity above the limit with the spare data bits set, widest element
    write_reg(rqsm_pkg::CFG_CAPACITY, 13'h1FFF);
    write_reg(rqsm_pkg::CFG_ELEM_SIZE, 13'h1FFF);
    send_req(rqsm_pkg::CMD_ALLOC_RUN, 11'd1023);
    send_req(rqsm_pkg::CMD_ALLOC, 11'd0);
    send_req(rqsm_pkg::CMD_STATUS, 11'd0);
    wait_drained();
    write_reg(rqsm_pkg::CFG_ELEM_SIZE, 13'd0);
    send_req(rqsm_pkg::CMD_PEEK, 11'd0);
    send_req(rqsm_pkg::CMD_RESET, 11'd0);
    wait_drained();
    // zero capacity behaves as a single slot
    write_reg(rqsm_pkg::CFG_CAPACITY, 13'd0);
    write_reg(rqsm_pkg::CFG_ELEM_SIZE, 13'd4096);
    send_req(rqsm_pkg::CMD_ALLOC, 11'd0);
    send_req(rqsm_pkg::CMD_ALLOC, 11'd0);
    send_req(rqsm_pkg::CMD_POP, 11'd0);
    send_req(rqsm_pkg::CMD_ALLOC_RUN, 11'd1);
    send_req(rqsm_pkg::CMD_FREE, 11'd1);
  endtask

  task automatic test_capacity_shrink();
    wait_drained();
    write_reg(rqsm_pkg::CFG_CAPACITY, 13'd1024);
    write_reg(rqsm_pkg::CFG_ELEM_SIZE, 13'd3);
    send_req(rqsm_pkg::CMD_RESET, 11'd0);
    send_req(rqsm_pkg::CMD_ALLOC_RUN, 11'd1024);
    wait_drained();
    write_reg(rqsm_pkg::CFG_CAPACITY, 13'd1000);
    send_req(rqsm_pkg::CMD_FREE, 11'd1010);
    wait_drained();
    // tail now far beyond the ring size
    write_reg(rqsm_pkg::CFG_CAPACITY, 13'd300);
    send_req(rqsm_pkg::CMD_ALLOC_RUN, 11'd5);
    send_req(rqsm_pkg::CMD_ALLOC, 11'd0);
    send_req(rqsm_pkg::CMD_FREE, 11'd3);
    send_req(rqsm_pkg::CMD_POP, 11'd0);
    send_req(rqsm_pkg::CMD_STATUS, 11'd0);
  endtask

  task automatic test_output_hold();
    wait_drained();
    write_reg(rqsm_pkg::CFG_CAPACITY, 13'd48);
    write_reg(rqsm_pkg::CFG_ELEM_SIZE, 13'd17);
    rx_hold_len = 200;
    repeat (24) send_random_req();
    wait_drained();
  endtask

  task automatic test_random_phases();
    int unsigned cap_set[8]  = '{2, 16, 1024, 0, 64, 2047, 5, 300};
    int unsigned size_set[8] = '{1, 4096, 0, 8191, 7, 1000, 4095, 1};
    logic [CFG_W-1:0] data;
    for (int p = 0; p < 8; p++) begin
      wait_drained(16);
      data = CFG_W'(cap_set[p]);
      data[CFG_W-1:CNT_W] = 2'($urandom_range(0, 3));
      write_reg(rqsm_pkg::CFG_CAPACITY, data);
      write_reg(rqsm_pkg::CFG_ELEM_SIZE, CFG_W'(size_set[p]));
      tx_idle_on  = (p % 3 != 2);
      rx_stall_on = (p % 3 != 1);
      repeat (220) send_random_req();
    end
  endtask

  task automatic test_no_idle();
    wait_drained(16);
    tx_idle_on  = 1'b0;
    rx_stall_on = 1'b0;
    write_reg(rqsm_pkg::CFG_CAPACITY, 13'd32);
    write_reg(rqsm_pkg::CFG_ELEM_SIZE, 13'd1);
    repeat (200) send_random_req();
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_and_full();
    test_register_extremes();
    test_capacity_shrink();
    test_output_hold();
    test_random_phases();
    test_no_idle();
    wait_drained(20);
    if (mismatch_count == 0 && slot_expect_q.size() == 0) begin
      $display("tb_ring_queue_slot_manager OK");
    end else begin
      $display("tb_ring_queue_slot_manager NOT OK");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("tb_ring_queue_slot_manager NOT OK");
    $finish;
  end

endmodule
